/* src/svm_pkg.sv */
// Shared operation codes and the saturating add used by the voice mixer.
package svm_pkg;

	localparam int SAMPLE_W = 16;

	typedef enum logic [2:0] {
		OP_TRIGGER   = 3'd0,
		OP_APPLY     = 3'd1,
		OP_MIX       = 3'd2,
		OP_WRITE     = 3'd3,
		OP_DESCRIBE  = 3'd4
	} op_t;

	localparam logic signed [SAMPLE_W-1:0] CLAMP_HIGH = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] CLAMP_LOW  = 16'sh8000;

	// Adds two signed words and saturates the sum to the word range.
	function automatic logic signed [SAMPLE_W-1:0] clamp_add(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b
	);
		logic signed [SAMPLE_W:0] s;
		logic signed [SAMPLE_W-1:0] r;
		s = SAMPLE_W'(0) + {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		if (s > $signed({CLAMP_HIGH[SAMPLE_W-1], CLAMP_HIGH})) begin
			r = CLAMP_HIGH;
		end else if (s < $signed({CLAMP_LOW[SAMPLE_W-1], CLAMP_LOW})) begin
			r = CLAMP_LOW;
		end else begin
			r = s[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

/* src/svm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module svm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/sample_voice_mixer.sv */
// Top level of the polyphonic sample playback mixer.
//
// Usage. A command beat is taken when start is high and busy is low; op selects
// trigger, apply pending triggers, mix one frame, write a sample word or set a
// sound descriptor. Every command returns exactly one result beat: done is high
// for one cycle with is_frame, left_sample, right_sample and active_voices.
// Only a mix command returns a frame; all other results carry zeros.
// The user must write the channel count register via cfg_we and cfg_wdata only while
// the block is idle; the block does not enforce it. 1 selects mono, other values stereo.
//
// Sequence. Trigger, sample write, descriptor write and unused codes go straight
// to the result beat. Apply walks the sounds one at a time and, for each pending
// sound with a nonzero length, scans the voices through the voice RAM read port,
// reading each active voice until one already holds the sound. Mix visits every
// voice through the same port: an idle voice is skipped, and a playing one reads
// its voice word, its descriptor and one sample word (mono) or two (stereo) from
// the single sample RAM read port, adding each with the clamp adder, then writes
// its voice word back. The block is busy throughout.
//
// Reset clears the triggers, the voice flags and the descriptor valid flags, so
// all sounds read absent; the sample store holds garbage until written. The
// receiver cannot stall: each result beat must be taken in its cycle.
// SAMPLE_WORDS must be a power of two (the block does not enforce it); sample addresses wrap at it.
module sample_voice_mixer
	import svm_pkg::*;
#(
	parameter int VOICE_COUNT  = 32,
	parameter int SOUND_COUNT  = 8,
	parameter int SAMPLE_WORDS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic [2:0]         sound_id,
	input  logic               cut,
	input  logic [15:0]        address,
	input  logic signed [15:0] sample_value,
	input  logic [15:0]        length_frames,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	output logic               done,
	output logic               is_frame,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample,
	output logic [5:0]         active_voices
);

	localparam int VIW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int SIW = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
	localparam int AW  = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
	localparam int VCW = VIW + 1;
	localparam int SCW = SIW + 1;
	localparam int VRW = SIW + 16;

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_AP_SND   = 13'b0000000000010,
		S_AP_DESC  = 13'b0000000000100,
		S_AP_VRD   = 13'b0000000001000,
		S_AP_VCHK  = 13'b0000000010000,
		S_AP_COMMIT= 13'b0000000100000,
		S_MX_SCAN  = 13'b0000001000000,
		S_MX_VDAT  = 13'b0000010000000,
		S_MX_DDAT  = 13'b0000100000000,
		S_MX_S0    = 13'b0001000000000,
		S_MX_S1    = 13'b0010000000000,
		S_MX_WB    = 13'b0100000000000,
		S_DONE     = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [1:0]             chan_cnt_q;
	logic                   stereo_q;
	logic [SOUND_COUNT-1:0] pend_on_q;
	logic [SOUND_COUNT-1:0] pend_cut_q;
	logic [SOUND_COUNT-1:0] desc_vld_q;
	logic [VOICE_COUNT-1:0] vact_q;

	logic [SCW-1:0]         snd_q;
	logic [VCW-1:0]         v_q;
	logic                   found_q;
	logic [VIW-1:0]         hit_q;
	logic                   free_found_q;
	logic [VIW-1:0]         free_q;

	logic [SIW-1:0]         vsnd_q;
	logic [15:0]            vpos_q;
	logic [15:0]            len_q;
	logic [AW-1:0]          addr_q;
	logic signed [15:0]     acc0_q;
	logic signed [15:0]     acc1_q;
	logic [5:0]             count_q;
	logic                   frame_q;

	// RAM ports.
	logic           v_we;
	logic [VIW-1:0] v_waddr;
	logic [VRW-1:0] v_wdata;
	logic [VRW-1:0] v_rdata;
	logic           d_we;
	logic [SIW-1:0] d_raddr;
	logic [31:0]    d_rdata;
	logic           s_we;
	logic [AW-1:0]  s_raddr;
	logic [15:0]    s_rdata;

	logic           accept;
	logic           id_ok;
	logic [SIW-1:0] id_idx;
	logic [VIW-1:0] v_idx;
	logic [SIW-1:0] snd_idx;
	logic [15:0]    ap_len;
	logic [15:0]    mx_len;
	logic [15:0]    mx_base;
	logic [17:0]    addr_sum;
	logic [AW+17:0] addr_ext;
	logic [AW+15:0] waddr_ext;
	logic [16:0]    pos_inc;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign id_ok     = (7'(sound_id) < 7'(SOUND_COUNT));
	assign id_idx    = SIW'({{SIW{1'b0}}, sound_id});
	assign v_idx     = v_q[VIW-1:0];
	assign snd_idx   = snd_q[SIW-1:0];
	assign ap_len    = desc_vld_q[snd_idx] ? d_rdata[15:0] : 16'd0;
	assign mx_len    = desc_vld_q[vsnd_q] ? d_rdata[15:0] : 16'd0;
	assign mx_base   = d_rdata[31:16];
	// Frame start address: base plus position times channels, wrapped.
	assign addr_sum  = {2'b00, mx_base} + (stereo_q ? {1'b0, vpos_q, 1'b0} : {2'b00, vpos_q});
	assign addr_ext  = {{AW{1'b0}}, addr_sum};
	assign waddr_ext = {{AW{1'b0}}, address};
	assign pos_inc   = {1'b0, vpos_q} + 17'd1;

	always_comb begin
		v_we    = 1'b0;
		v_waddr = v_idx;
		v_wdata = {vsnd_q, pos_inc[15:0]};
		if (state_q == S_AP_COMMIT) begin
			if (found_q) begin
				v_we    = pend_cut_q[snd_idx];
				v_waddr = hit_q;
			end else begin
				v_we    = 1'b1;
				v_waddr = free_found_q ? free_q : '0;
			end
			v_wdata = {snd_idx, 16'd0};
		end else if (state_q == S_MX_WB) begin
			v_we = 1'b1;
		end
	end

	assign d_we    = accept && (op == OP_DESCRIBE) && id_ok;
	assign d_raddr = (state_q == S_MX_VDAT) ? v_rdata[VRW-1:16] : snd_idx;
	assign s_we    = accept && (op == OP_WRITE);
	assign s_raddr = (state_q == S_MX_DDAT) ? addr_ext[AW-1:0] : addr_q + AW'(1);

	svm_ram #(.WIDTH(VRW), .DEPTH(VOICE_COUNT), .AW(VIW)) u_voice_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_idx),
		.rdata (v_rdata)
	);

	svm_ram #(.WIDTH(32), .DEPTH(SOUND_COUNT), .AW(SIW)) u_desc_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (id_idx),
		.wdata ({address, length_frames}),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	svm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS), .AW(AW)) u_sample_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (waddr_ext[AW-1:0]),
		.wdata (sample_value),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// Payload registers of the walk; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc0_q  <= '0;
				acc1_q  <= '0;
				count_q <= '0;
				frame_q <= (op == OP_MIX);
				stereo_q <= (chan_cnt_q != 2'd1);
			end
			S_AP_DESC: begin
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			S_AP_VRD: begin
				if ((v_q != VCW'(VOICE_COUNT)) && !vact_q[v_idx] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= v_idx;
				end
			end
			S_AP_VCHK: begin
				if (v_rdata[VRW-1:16] == snd_idx) begin
					found_q <= 1'b1;
					hit_q   <= v_idx;
				end
			end
			S_MX_VDAT: begin
				vsnd_q <= v_rdata[VRW-1:16];
				vpos_q <= v_rdata[15:0];
			end
			S_MX_DDAT: begin
				len_q  <= mx_len;
				addr_q <= addr_ext[AW-1:0];
				if ((mx_len != 16'd0) && (vpos_q >= mx_len)) begin
					count_q <= count_q + 6'd1;
				end
			end
			S_MX_S0: acc0_q <= clamp_add(acc0_q, s_rdata);
			S_MX_S1: acc1_q <= clamp_add(acc1_q, s_rdata);
			S_MX_WB: count_q <= count_q + 6'd1;
			default: ;
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			chan_cnt_q <= 2'd2;
			pend_on_q  <= '0;
			pend_cut_q <= '0;
			desc_vld_q <= '0;
			vact_q     <= '0;
			snd_q      <= '0;
			v_q        <= '0;
		end else begin
			if (cfg_we) begin
				chan_cnt_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					snd_q <= '0;
					v_q   <= '0;
					if (start) begin
						case (op)
							OP_TRIGGER: begin
								if (id_ok && !pend_on_q[id_idx]) begin
									pend_on_q[id_idx]  <= 1'b1;
									pend_cut_q[id_idx] <= cut;
								end
								state_q <= S_DONE;
							end
							OP_APPLY: state_q <= S_AP_SND;
							OP_MIX:   state_q <= S_MX_SCAN;
							OP_DESCRIBE: begin
								if (id_ok) begin
									desc_vld_q[id_idx] <= 1'b1;
								end
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_AP_SND: begin
					v_q <= '0;
					if (snd_q == SCW'(SOUND_COUNT)) begin
						state_q <= S_DONE;
					end else if (!pend_on_q[snd_idx]) begin
						snd_q <= snd_q + SCW'(1);
					end else begin
						state_q <= S_AP_DESC;
					end
				end
				S_AP_DESC: begin
					if (ap_len == 16'd0) begin
						snd_q   <= snd_q + SCW'(1);
						state_q <= S_AP_SND;
					end else begin
						state_q <= S_AP_VRD;
					end
				end
				S_AP_VRD: begin
					if (v_q == VCW'(VOICE_COUNT)) begin
						state_q <= S_AP_COMMIT;
					end else if (!vact_q[v_idx]) begin
						v_q <= v_q + VCW'(1);
					end else begin
						state_q <= S_AP_VCHK;
					end
				end
				S_AP_VCHK: begin
					if (v_rdata[VRW-1:16] == snd_idx) begin
						state_q <= S_AP_COMMIT;
					end else begin
						v_q     <= v_q + VCW'(1);
						state_q <= S_AP_VRD;
					end
				end
				S_AP_COMMIT: begin
					if (!found_q) begin
						vact_q[free_found_q ? free_q : '0] <= 1'b1;
					end
					pend_on_q[snd_idx]  <= 1'b0;
					pend_cut_q[snd_idx] <= 1'b0;
					snd_q   <= snd_q + SCW'(1);
					state_q <= S_AP_SND;
				end
				S_MX_SCAN: begin
					if (v_q == VCW'(VOICE_COUNT)) begin
						state_q <= S_DONE;
					end else if (!vact_q[v_idx]) begin
						v_q <= v_q + VCW'(1);
					end else begin
						state_q <= S_MX_VDAT;
					end
				end
				S_MX_VDAT: state_q <= S_MX_DDAT;
				S_MX_DDAT: begin
					if ((mx_len == 16'd0) || (vpos_q >= mx_len)) begin
						vact_q[v_idx] <= 1'b0;
						v_q     <= v_q + VCW'(1);
						state_q <= S_MX_SCAN;
					end else begin
						state_q <= S_MX_S0;
					end
				end
				S_MX_S0: state_q <= stereo_q ? S_MX_S1 : S_MX_WB;
				S_MX_S1: state_q <= S_MX_WB;
				S_MX_WB: begin
					if (pos_inc >= {1'b0, len_q}) begin
						vact_q[v_idx] <= 1'b0;
					end
					v_q     <= v_q + VCW'(1);
					state_q <= S_MX_SCAN;
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done          = (state_q == S_DONE);
	assign is_frame      = done && frame_q;
	assign left_sample   = is_frame ? acc0_q : 16'sd0;
	assign right_sample  = (is_frame && stereo_q) ? acc1_q : 16'sd0;
	assign active_voices = is_frame ? count_q : 6'd0;

endmodule

/* src/svm_checker.sv */
// Port-level checks on the mixer's command and result beats, bound to the top.
module svm_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               is_frame,
	input logic signed [15:0] left_sample,
	input logic signed [15:0] right_sample,
	input logic [5:0]         active_voices
);

	// An accepted command beat keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted command did not raise busy");

	// A result beat only appears while a command is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat while idle");

	// After a result beat the block is ready again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result beat");

	// Result fields are quiet outside a frame beat.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!is_frame |-> (left_sample == 16'sd0 && right_sample == 16'sd0 &&
		active_voices == 6'd0)) else $error("result fields not zero");

	// A frame is only reported on a result beat.
	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		is_frame |-> done) else $error("frame without result beat");

endmodule

bind sample_voice_mixer svm_port_checks u_port_checks (.*);
